// ===== sv/sh3_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sh3_pkg
// Shared types and constants of the 3x3 RGB sharpen filter.
// ----------------------------------------------------------------------------
package sh3_pkg;

    // packed pixel, red in the top byte
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    // which results one pixel produces, decided at accept time
    typedef struct packed {
        logic has_pre;   // pixel up-left of the arriving one
        logic sharp;     // that pixel is interior and gets the kernel
        logic has_up;    // pixel above, at the row end
        logic has_own;   // arriving pixel itself, last row
        logic row_end;   // arriving pixel closes its row
    } t_emit;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    // register reset values
    localparam int FRAME_WIDTH_RST  = 640;
    localparam int FRAME_HEIGHT_RST = 480;

    // neighborhood layout
    localparam int NB_SIZE  = 9;
    localparam int WIN_SIZE = 6;

    // result queue
    localparam int RES_FIFO_DEPTH = 8;
    localparam int MAX_PUSH       = 3;
    localparam int PUSH_W         = 2;

    // result entry: {col, row, pixel, run_last, frame_done}
    localparam int LAST_BIT = 1;
    localparam int DONE_BIT = 0;

endpackage

// ===== sv/sharpen_3x3_rgb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sharpen_3x3_rgb
// Streaming 3x3 Laplacian sharpen of an RGB frame in raster order, with
// border pass-through and per-result coordinates.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                    payload
//  pixel    in         i_in_valid / o_in_ready      i_red_in i_green_in i_blue_in
//  result   out        o_out_valid / i_out_ready    o_out_col o_out_row o_*_out
//                                                   o_run_last o_frame_done
//  config   in         i_cfg_we                     i_cfg_idx i_cfg_data
//
//  One pixel beat per cycle while o_in_ready is high; line stores are read
//  on accept and written back when the beat leaves the first stage, and a
//  result passes stage 1, the kernel stage and the result queue on its way out.
//  A row-end pixel can cause up to three results; the eight-entry result
//  queue drains one per cycle while i_out_ready is high, the kernel stage waits
//  while it holds more than five, and the input stalls once both stages are full.
//  Reset clears counters, window and queue; line stores need no clearing.
// ----------------------------------------------------------------------------
module sharpen_3x3_rgb import sh3_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4095,
    localparam int CW = $clog2(MAX_WIDTH),
    localparam int RW = $clog2(MAX_HEIGHT),
    localparam int WW = $clog2(MAX_WIDTH + 1),
    localparam int HW = $clog2(MAX_HEIGHT + 1),
    localparam int DW = (WW > HW) ? WW : HW
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DW-1:0]        i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [7:0]           i_red_in,
    input  logic [7:0]           i_green_in,
    input  logic [7:0]           i_blue_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [CW-1:0]        o_out_col,
    output logic [RW-1:0]        o_out_row,
    output logic [7:0]           o_red_out,
    output logic [7:0]           o_green_out,
    output logic [7:0]           o_blue_out,
    output logic                 o_run_last,
    output logic                 o_frame_done
);

    localparam int EW = CW + RW + $bits(t_rgb) + 2;

    t_rgb                        in_pix;
    logic                        lw_valid, kn_ready;
    t_rgb [NB_SIZE-1:0]          lw_nb;
    logic [CW-1:0]               lw_col;
    logic [RW-1:0]               lw_row;
    t_emit                       lw_emit;
    logic                        q_room;
    logic [PUSH_W-1:0]           push_n;
    logic [MAX_PUSH-1:0][EW-1:0] push_ent;
    logic [EW-1:0]               head;
    t_rgb                        head_pix;

    assign in_pix = '{red: i_red_in, green: i_green_in, blue: i_blue_in};

    // line stores, counters and window
    sh3_line_window #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_line_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_in_valid),
        .o_ready    (o_in_ready),
        .i_pix      (in_pix),
        .o_valid    (lw_valid),
        .i_ready    (kn_ready),
        .o_nb       (lw_nb),
        .o_col      (lw_col),
        .o_row      (lw_row),
        .o_emit     (lw_emit)
    );

    // kernel and result assembly
    sh3_kernel #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_kernel (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (lw_valid),
        .o_ready  (kn_ready),
        .i_nb     (lw_nb),
        .i_col    (lw_col),
        .i_row    (lw_row),
        .i_emit   (lw_emit),
        .i_room   (q_room),
        .o_push_n (push_n),
        .o_ent    (push_ent)
    );

    // result queue
    sh3_res_fifo #(
        .WIDTH (EW)
    ) u_res_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (push_n),
        .i_ent    (push_ent),
        .o_room   (q_room),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_ent    (head)
    );

    // unpack the head entry
    assign o_out_col    = head[EW-1 -: CW];
    assign o_out_row    = head[EW-CW-1 -: RW];
    assign head_pix     = head[$bits(t_rgb)+1 : 2];
    assign o_red_out    = head_pix.red;
    assign o_green_out  = head_pix.green;
    assign o_blue_out   = head_pix.blue;
    assign o_run_last   = head[LAST_BIT];
    assign o_frame_done = head[DONE_BIT];

endmodule

// ===== sv/sh3_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sh3_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sh3_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/sh3_line_window.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sh3_line_window
// Frame registers, raster counters, the two line stores and the window.
// Reads the line stores on accept, writes them back when stage 1 moves on and
// shifts the window, presenting the full 3x3 neighborhood downstream.
// ----------------------------------------------------------------------------
module sh3_line_window import sh3_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4095,
    localparam int CW = $clog2(MAX_WIDTH),
    localparam int RW = $clog2(MAX_HEIGHT),
    localparam int WW = $clog2(MAX_WIDTH + 1),
    localparam int HW = $clog2(MAX_HEIGHT + 1),
    localparam int DW = (WW > HW) ? WW : HW
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DW-1:0]        i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  t_rgb                 i_pix,
    output logic                 o_valid,
    input  logic                 i_ready,
    output t_rgb [NB_SIZE-1:0]   o_nb,
    output logic [CW-1:0]        o_col,
    output logic [RW-1:0]        o_row,
    output t_emit                o_emit
);

    localparam int W_RST = (FRAME_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : FRAME_WIDTH_RST;
    localparam int H_RST = (FRAME_HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT : FRAME_HEIGHT_RST;

    logic [WW-1:0] r_wcfg;
    logic [HW-1:0] r_hcfg;
    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;

    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic          row_end, last_row;
    t_emit         emit;

    logic          accept, s1_fire;
    logic          r_s1_valid;
    logic [CW-1:0] r_s1_c;
    logic [RW-1:0] r_s1_r;
    t_rgb          r_s1_cur;
    t_emit         r_s1_emit;

    logic          r_fwd;
    t_rgb          r_fwd_old, r_fwd_new;
    t_rgb          old_ram, new_ram;
    t_rgb          old_eff, new_eff;
    t_rgb          r_win [WIN_SIZE];

    // frame size registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wcfg <= WW'(W_RST);
            r_hcfg <= HW'(H_RST);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_FRAME_WIDTH:  r_wcfg <= i_cfg_data[WW-1:0];
                REG_FRAME_HEIGHT: r_hcfg <= i_cfg_data[HW-1:0];
            endcase
        end
    end

    // saturate frame size to 1..max
    always_comb begin
        priority if (r_wcfg == '0)             w_eff = WW'(1);
        else if (r_wcfg > WW'(MAX_WIDTH))      w_eff = WW'(MAX_WIDTH);
        else                                   w_eff = r_wcfg;
        priority if (r_hcfg == '0)             h_eff = HW'(1);
        else if (r_hcfg > HW'(MAX_HEIGHT))     h_eff = HW'(MAX_HEIGHT);
        else                                   h_eff = r_hcfg;
    end

    // position of the arriving pixel and the results it causes
    always_comb begin
        row_end  = (WW'(r_col) + WW'(1)) >= w_eff;
        last_row = (HW'(r_row) + HW'(1)) >= h_eff;

        emit.has_pre = (r_row != '0) && (r_col != '0);
        emit.sharp   = (r_col >= CW'(2)) && (WW'(r_col) < w_eff)
                    && (r_row >= RW'(2)) && (HW'(r_row) < h_eff);
        emit.has_up  = (r_row != '0) && row_end;
        emit.has_own = last_row;
        emit.row_end = row_end;

        if (row_end) begin
            n_col = '0;
            n_row = last_row ? '0 : r_row + RW'(1);
        end else begin
            n_col = r_col + CW'(1);
            n_row = r_row;
        end
    end

    assign accept  = i_valid && o_ready;
    assign s1_fire = r_s1_valid && i_ready;
    assign o_ready = !r_s1_valid || i_ready;

    // raster counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // stage 1 control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd      <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
                r_fwd      <= s1_fire && (r_col == r_s1_c);
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    // stage 1 payload and forwarded write-back data
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_c    <= r_col;
            r_s1_r    <= r_row;
            r_s1_cur  <= i_pix;
            r_s1_emit <= emit;
            r_fwd_old <= new_eff;
            r_fwd_new <= r_s1_cur;
        end
    end

    // line stores: read on accept, write back when stage 1 moves on
    sh3_ram #(
        .WIDTH ($bits(t_rgb)),
        .DEPTH (MAX_WIDTH)
    ) u_older_line (
        .i_clk   (i_clk),
        .i_we    (s1_fire),
        .i_waddr (r_s1_c),
        .i_wdata (new_eff),
        .i_re    (accept),
        .i_raddr (r_col),
        .o_rdata (old_ram)
    );

    sh3_ram #(
        .WIDTH ($bits(t_rgb)),
        .DEPTH (MAX_WIDTH)
    ) u_newer_line (
        .i_clk   (i_clk),
        .i_we    (s1_fire),
        .i_waddr (r_s1_c),
        .i_wdata (r_s1_cur),
        .i_re    (accept),
        .i_raddr (r_col),
        .o_rdata (new_ram)
    );

    // bypass when the previous beat wrote the same column in the read cycle
    assign old_eff = r_fwd ? r_fwd_old : old_ram;
    assign new_eff = r_fwd ? r_fwd_new : new_ram;

    // two-column window shift
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WIN_SIZE; i++) begin
                r_win[i] <= '0;
            end
        end else if (s1_fire) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= old_eff;
            r_win[4] <= new_eff;
            r_win[5] <= r_s1_cur;
        end
    end

    // neighborhood, row-major with the center at index 4
    always_comb begin
        o_nb[0] = r_win[0];
        o_nb[1] = r_win[3];
        o_nb[2] = old_eff;
        o_nb[3] = r_win[1];
        o_nb[4] = r_win[4];
        o_nb[5] = new_eff;
        o_nb[6] = r_win[2];
        o_nb[7] = r_win[5];
        o_nb[8] = r_s1_cur;
    end

    assign o_valid = r_s1_valid;
    assign o_col   = r_s1_c;
    assign o_row   = r_s1_r;
    assign o_emit  = r_s1_emit;

    // counters never leave the largest frame
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= CW'(MAX_WIDTH - 1))
        else $error("column counter beyond maximum width");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= RW'(MAX_HEIGHT - 1))
        else $error("row counter beyond maximum height");

endmodule

// ===== sv/sh3_kernel.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sh3_kernel
// Holds one neighborhood, applies the 3x3 sharpen kernel and builds the
// up to three result entries of that beat in emission order.
// ----------------------------------------------------------------------------
module sh3_kernel import sh3_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4095,
    localparam int CW = $clog2(MAX_WIDTH),
    localparam int RW = $clog2(MAX_HEIGHT),
    localparam int EW = CW + RW + $bits(t_rgb) + 2
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  t_rgb [NB_SIZE-1:0]           i_nb,
    input  logic [CW-1:0]                i_col,
    input  logic [RW-1:0]                i_row,
    input  t_emit                        i_emit,
    input  logic                         i_room,
    output logic [PUSH_W-1:0]            o_push_n,
    output logic [MAX_PUSH-1:0][EW-1:0]  o_ent
);

    logic                r_valid;
    t_rgb [NB_SIZE-1:0]  r_nb;
    logic [CW-1:0]       r_c;
    logic [RW-1:0]       r_r;
    t_emit               r_emit;

    logic                fire;
    logic [NB_SIZE-1:0][7:0] v_red, v_green, v_blue;
    t_rgb                sharp_pix, pre_pix;
    logic [EW-1:0]       e_pre, e_up, e_own;
    logic [PUSH_W-1:0]   cnt;

    // one channel: 9 * center minus the eight neighbors, clamped to 0..255
    function automatic logic [7:0] f_sharp_chan(input logic [NB_SIZE-1:0][7:0] v);
        logic signed [12:0] acc;
        acc = 13'(9) * {5'b0, v[4]};
        for (int i = 0; i < NB_SIZE; i++) begin
            if (i != 4) begin
                acc = acc - {5'b0, v[i]};
            end
        end
        if (acc[12]) begin
            return 8'd0;
        end else if (acc[11:8] != 4'd0) begin
            return 8'd255;
        end else begin
            return acc[7:0];
        end
    endfunction

    assign fire    = r_valid && i_room;
    assign o_ready = !r_valid || i_room;

    // stage 2 control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (fire) begin
            r_valid <= 1'b0;
        end
    end

    // stage 2 payload
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_nb   <= i_nb;
            r_c    <= i_col;
            r_r    <= i_row;
            r_emit <= i_emit;
        end
    end

    // split channels and run the kernel
    always_comb begin
        for (int i = 0; i < NB_SIZE; i++) begin
            v_red[i]   = r_nb[i].red;
            v_green[i] = r_nb[i].green;
            v_blue[i]  = r_nb[i].blue;
        end
        sharp_pix.red   = f_sharp_chan(v_red);
        sharp_pix.green = f_sharp_chan(v_green);
        sharp_pix.blue  = f_sharp_chan(v_blue);
        pre_pix = r_emit.sharp ? sharp_pix : r_nb[4];
    end

    // candidate entries, run_last filled in below
    assign e_pre = {r_c - CW'(1), r_r - RW'(1), pre_pix, 1'b0, 1'b0};
    assign e_up  = {r_c, r_r - RW'(1), r_nb[5], 1'b0, 1'b0};
    assign e_own = {r_c, r_r, r_nb[8], 1'b0, r_emit.row_end};

    // pack present results in emission order, mark the last one
    always_comb begin
        o_ent = '0;
        cnt   = '0;
        if (r_emit.has_pre) begin
            o_ent[cnt] = e_pre;
            cnt = cnt + PUSH_W'(1);
        end
        if (r_emit.has_up) begin
            o_ent[cnt] = e_up;
            cnt = cnt + PUSH_W'(1);
        end
        if (r_emit.has_own) begin
            o_ent[cnt] = e_own;
            cnt = cnt + PUSH_W'(1);
        end
        if (cnt != '0) begin
            o_ent[cnt - PUSH_W'(1)][LAST_BIT] = 1'b1;
        end
        o_push_n = fire ? cnt : '0;
    end

    // the up-left pixel only exists away from the first row and column
    a_pre_coords: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_emit.has_pre) |-> (r_c != '0 && r_r != '0))
        else $error("up-left result at first row or column");

    // the kernel only runs on pixels with a full neighborhood above
    a_sharp_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_emit.has_pre && r_emit.sharp) |-> (r_c >= CW'(2) && r_r >= RW'(2)))
        else $error("kernel applied at the frame border");

endmodule

// ===== sv/sh3_res_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sh3_res_fifo
// Result queue: takes up to three entries in one cycle, hands out one.
// ----------------------------------------------------------------------------
module sh3_res_fifo import sh3_pkg::*; #(
    parameter int WIDTH = 48
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [PUSH_W-1:0]              i_push_n,
    input  logic [MAX_PUSH-1:0][WIDTH-1:0] i_ent,
    output logic                           o_room,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [WIDTH-1:0]               o_ent
);

    localparam int PW   = $clog2(RES_FIFO_DEPTH);
    localparam int CNTW = $clog2(RES_FIFO_DEPTH + 1);

    logic [WIDTH-1:0] r_mem [RES_FIFO_DEPTH];
    logic [PW-1:0]    r_wr, r_rd;
    logic [CNTW-1:0]  r_count, n_count;
    logic             pop;

    assign pop     = o_valid && i_ready;
    assign o_valid = r_count != '0;
    assign o_room  = r_count <= CNTW'(RES_FIFO_DEPTH - MAX_PUSH);
    assign o_ent   = r_mem[r_rd];
    assign n_count = r_count + CNTW'(i_push_n) - CNTW'(pop);

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + PW'(i_push_n);
            r_rd    <= r_rd + PW'(pop);
            r_count <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_PUSH; k++) begin
            if (PUSH_W'(k) < i_push_n) begin
                r_mem[PW'(r_wr + PW'(k))] <= i_ent[k];
            end
        end
    end

    // a push never lands on unread entries
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push_n != '0) |-> (r_count <= CNTW'(RES_FIFO_DEPTH - MAX_PUSH)))
        else $error("result queue overflow");

endmodule
